[hw/rtl/ldfr_pkg.sv]
// Shared types and constants for the LED dimmer fade ramp.
package ldfr_pkg;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_SWITCH = 2'd2;

   localparam logic [7:0] SWITCH_OFF = 8'd0;
   localparam logic [7:0] SWITCH_ON  = 8'd1;

   localparam logic [7:0] CSR_STEP_SIZE       = 8'd0;
   localparam logic [7:0] CSR_UPDATE_INTERVAL = 8'd1;

   localparam logic [6:0] FULL_LEVEL        = 7'd100;
   localparam logic [6:0] STEP_RESET        = 7'd1;
   localparam logic [7:0] INTERVAL_RESET    = 8'd10;

   localparam int RSP_DATA_W = 32;

   // Lowest field last, so duty_permill sits in the low bits when packed.
   typedef struct packed {
      logic       light_on;
      logic       fading;
      logic [6:0] target;
      logic [6:0] brightness;
      logic [9:0] duty_permill;
   } rsp_type;

endpackage

[hw/rtl/ldfr_engine.sv]
// Fade state registers and the per-item next-state logic.
module ldfr_engine (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_accept,
   input  logic [1:0]      opcode,
   input  logic [7:0]      value,
   input  logic [6:0]      step_size,
   input  logic [7:0]      update_interval,
   output ldfr_pkg::rsp_type result
);
   import ldfr_pkg::*;

   logic [6:0] cur_ff, cur_in;
   logic [6:0] goal_ff, goal_in;
   logic [6:0] mem_ff, mem_in;
   logic       ramp_ff, ramp_in;
   logic [7:0] elapsed_ff, elapsed_in;

   logic [7:0] elapsed_inc;
   logic [6:0] mag;
   logic [7:0] up_sum;
   logic       set_req;
   logic [7:0] set_pct;

   always_comb begin
      cur_in     = cur_ff;
      goal_in    = goal_ff;
      mem_in     = mem_ff;
      ramp_in    = ramp_ff;
      elapsed_in = elapsed_ff;
      set_req    = 1'b0;
      set_pct    = value;

      elapsed_inc = (elapsed_ff < update_interval) ? elapsed_ff + 8'd1 : update_interval;
      mag    = (goal_ff >= cur_ff) ? goal_ff - cur_ff : cur_ff - goal_ff;
      up_sum = {1'b0, cur_ff} + {1'b0, step_size};

      case (opcode)
         OP_TICK: begin
            elapsed_in = elapsed_inc;
            if (ramp_ff && elapsed_inc >= update_interval) begin
               elapsed_in = 8'd0;
               if (mag <= step_size) begin
                  cur_in  = goal_ff;
                  ramp_in = 1'b0;
               end else if (goal_ff > cur_ff) begin
                  if (up_sum > {1'b0, FULL_LEVEL}) begin
                     cur_in  = FULL_LEVEL;
                     ramp_in = 1'b0;
                  end else begin
                     cur_in = up_sum[6:0];
                  end
               end else begin
                  if (cur_ff < step_size) begin
                     cur_in  = 7'd0;
                     ramp_in = 1'b0;
                  end else begin
                     cur_in = cur_ff - step_size;
                  end
               end
            end
         end
         OP_SET: begin
            set_req = 1'b1;
         end
         OP_SWITCH: begin
            if (value == SWITCH_OFF) begin
               set_req = 1'b1;
               set_pct = 8'd0;
            end else if (value == SWITCH_ON) begin
               set_req = 1'b1;
               set_pct = {1'b0, mem_ff};
            end
         end
         default: ;
      endcase

      if (set_req && set_pct <= {1'b0, FULL_LEVEL}) begin
         if (set_pct != 8'd0) begin
            mem_in = set_pct[6:0];
         end
         goal_in = set_pct[6:0];
         ramp_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff     <= 7'd0;
         goal_ff    <= 7'd0;
         mem_ff     <= FULL_LEVEL;
         ramp_ff    <= 1'b0;
         elapsed_ff <= INTERVAL_RESET;
      end else if (item_accept) begin
         cur_ff     <= cur_in;
         goal_ff    <= goal_in;
         mem_ff     <= mem_in;
         ramp_ff    <= ramp_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_comb begin
      result.duty_permill = {cur_in, 3'b000} + {2'b00, cur_in, 1'b0};
      result.brightness   = cur_in;
      result.target       = goal_in;
      result.fading       = ramp_in;
      result.light_on     = (goal_in != 7'd0);
   end

`ifndef ASSERT_OFF
   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= FULL_LEVEL) else $error("level above full scale");
   a_goal_range: assert property (@(posedge clock) disable iff (reset)
      goal_ff <= FULL_LEVEL) else $error("set point above full scale");
   a_mem_range: assert property (@(posedge clock) disable iff (reset)
      mem_ff != 7'd0 && mem_ff <= FULL_LEVEL) else $error("remembered level out of range");
`endif
endmodule

[hw/rtl/ldfr_out_buf.sv]
// Two-entry result buffer: output register plus skid stage.
module ldfr_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ldfr_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ldfr_pkg::rsp_type out_data
);
   import ldfr_pkg::*;

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    push;
   logic    pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end
         main_valid_ff <= 1'b1;
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= in_data;
         end else begin
            main_ff <= in_data;
         end
      end
   end

`ifndef ASSERT_OFF
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff) else $error("skid holds item without output item");
   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(main_valid_ff && !out_ready && in_valid))
      else $error("skid filled without a stall");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> !skid_valid_ff) else $error("skid not drained");
`endif
endmodule

[hw/rtl/led_dimmer_fade_ramp_core.sv]
// LED dimmer fade ramp: top level with configuration registers and stream ports.
//
// Usage:
//   req_ channel carries one item per handshake: req_tuser is the opcode
//   (tick, set brightness, switch on/off), req_tdata is the value.
//   rsp_ channel returns exactly one item per accepted request: duty in
//   permill, brightness, target, fading and on flags.
//   csr_ channel writes step_size (index 0) or update_interval (index 1);
//   other indexes are ignored. csr_ready is always high. Write only while idle.
// Timing:
//   An accepted item updates the fade state in the same cycle; its result is
//   registered in the output buffer and shown on rsp_. One item per cycle
//   sustained while rsp_ is not stalled, set by the next-state logic in ldfr_engine.
// Reset:
//   Level 0, target 0, remembered level 100, no fade, step 1, interval 10.
// Stall:
//   A two-entry output buffer keeps req_tready high for one more item while
//   rsp_ is stalled; then req_tready drops until the receiver takes an item.
module led_dimmer_fade_ramp_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] value
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [9:0] duty_permill, [16:10] brightness,
                                    // [23:17] target, [24] fading, [25] light_on
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import ldfr_pkg::*;

   logic [6:0] step_ff;
   logic [7:0] interval_ff;
   rsp_type    result;
   rsp_type    rsp_item;
   logic       accept;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= STEP_RESET;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_SIZE:       step_ff     <= csr_data[6:0];
            CSR_UPDATE_INTERVAL: interval_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ldfr_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .item_accept     (accept),
      .opcode          (req_tuser),
      .value           (req_tdata),
      .step_size       (step_ff),
      .update_interval (interval_ff),
      .result          (result)
   );

   ldfr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_item)
   );

   assign rsp_tdata = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_item};

endmodule

[sim/led_dimmer_fade_ramp_core_test.sv]
// Self-checking stream bench for the LED dimmer fade ramp core, scored against a built-in level model.
module led_dimmer_fade_ramp_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ldfr_pkg::*;

   localparam logic [1:0] OP_STATUS   = 2'd3;   // unused opcode, reports status only
   localparam int         DUTY_SCALE  = 10;
   localparam int         RSP_FIELD_W = $bits(rsp_type);
   localparam int         FADE_ITEMS  = 1550;
   localparam int         PHASES      = 14;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] val;
   } dimmer_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] value
   logic [1:0]  req_tuser = '0;    // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [9:0] duty_permill, [16:10] brightness,
                                   // [23:17] target, [24] fading, [25] light_on
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   led_dimmer_fade_ramp_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // fade state and register copies
   int lvl_now      = 0;
   int lvl_goal     = 0;
   int lvl_saved    = FULL_LEVEL;
   int tick_count   = INTERVAL_RESET;
   int step_cfg     = STEP_RESET;
   int interval_cfg = INTERVAL_RESET;
   bit ramp_on      = 1'b0;

   dimmer_cmd_type cmd_q[$];
   rsp_type        level_exp_q[$];

   bit calm = 1'b0;
   bit req_taken = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int sent_count = 0;
   int checked_count = 0;
   int fail_count = 0;
   int setting_count = 0;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void aim_at(int pct);
      if (pct > FULL_LEVEL) return;
      if (pct > 0) lvl_saved = pct;
      lvl_goal = pct;
      ramp_on  = 1'b1;
   endfunction

   function automatic rsp_type dimmer_predict(logic [1:0] op, logic [7:0] val);
      rsp_type r;
      int      diff;
      int      mag;
      case (op)
         OP_TICK: begin
            if (tick_count < interval_cfg) tick_count++;
            if (tick_count > interval_cfg) tick_count = interval_cfg;
            if (ramp_on && tick_count >= interval_cfg) begin
               diff = lvl_goal - lvl_now;
               mag  = (diff < 0) ? -diff : diff;
               if (mag <= step_cfg) begin
                  lvl_now = lvl_goal;
                  ramp_on = 1'b0;
               end else if (diff > 0) begin
                  lvl_now += step_cfg;
                  if (lvl_now > FULL_LEVEL) begin
                     lvl_now = FULL_LEVEL;
                     ramp_on = 1'b0;
                  end
               end else begin
                  lvl_now -= step_cfg;
                  if (lvl_now < 0) begin
                     lvl_now = 0;
                     ramp_on = 1'b0;
                  end
               end
               tick_count = 0;
            end
         end
         OP_SET: aim_at(val);
         OP_SWITCH: begin
            if (val == SWITCH_OFF) aim_at(0);
            else if (val == SWITCH_ON) aim_at(lvl_saved);
         end
         default: ;
      endcase
      r.duty_permill = 10'(lvl_now * DUTY_SCALE);
      r.brightness   = 7'(lvl_now);
      r.target       = 7'(lvl_goal);
      r.fading       = ramp_on;
      r.light_on     = (lvl_goal > 0);
      return r;
   endfunction

   // request side
   always @(posedge clock) begin : req_accept
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         level_exp_q.push_back(dimmer_predict(req_tuser, req_tdata));
         sent_count++;
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin : req_drive
      dimmer_cmd_type c;
      bit             v;
      c.op  = req_tuser;
      c.val = req_tdata;
      v     = req_tvalid;
      if (reset) begin
         v = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         v = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (cmd_q.size() > 0) begin
            c        = cmd_q.pop_front();
            v        = 1'b1;
            send_gap = calm ? 0 : idle_len();
         end
      end
      req_tvalid <= v;
      req_tuser  <= c.op;
      req_tdata  <= c.val;
   end

   // result side
   always @(negedge clock) begin : rsp_stall
      bit rdy;
      rdy = 1'b1;
      if (calm) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rdy = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = idle_len();
         rdy = (stall_left == 0);
      end
      rsp_tready <= rdy;
   end

   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_FIELD_W-1:0];
         if (level_exp_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result item: duty %0d bright %0d target %0d fade %0b on %0b",
                        got.duty_permill, got.brightness, got.target, got.fading, got.light_on);
         end else begin
            want = level_exp_q.pop_front();
            checked_count++;
            if (got.duty_permill != want.duty_permill || got.brightness != want.brightness ||
                got.target != want.target || got.fading != want.fading ||
                got.light_on != want.light_on || rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W] != '0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("result %0d mismatch at %0t", checked_count, $realtime);
                  $display("  exp: duty %0d bright %0d target %0d fade %0b on %0b",
                           want.duty_permill, want.brightness, want.target, want.fading,
                           want.light_on);
                  $display("  got: duty %0d bright %0d target %0d fade %0b on %0b pad %h",
                           got.duty_permill, got.brightness, got.target, got.fading,
                           got.light_on, rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W]);
               end
            end
         end
      end
   end

   task automatic csr_write(logic [7:0] idx, logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_STEP_SIZE:       step_cfg = data & 8'h7F;
         CSR_UPDATE_INTERVAL: interval_cfg = data;
         default: ;
      endcase
      setting_count++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold the sender until every expected item has come back
   task automatic wait_idle();
      @(posedge clock);
      while (cmd_q.size() != 0 || req_tvalid || level_exp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send(logic [1:0] op, logic [7:0] val, int count = 1);
      dimmer_cmd_type c;
      c.op  = op;
      c.val = val;
      repeat (count) cmd_q.push_back(c);
   endtask

   function automatic dimmer_cmd_type random_cmd();
      dimmer_cmd_type c;
      int             r;
      r = $urandom_range(0, 99);
      c.val = 8'($urandom_range(0, 255));
      if (r < 60) begin
         c.op = OP_TICK;
      end else if (r < 80) begin
         c.op  = OP_SET;
         c.val = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1) * 100)
                                             : 8'($urandom_range(0, 100));
      end else if (r < 83) begin
         c.op  = OP_SET;
         c.val = 8'($urandom_range(101, 255));
      end else if (r < 93) begin
         c.op  = OP_SWITCH;
         c.val = $urandom_range(0, 1) ? SWITCH_ON : SWITCH_OFF;
      end else if (r < 96) begin
         c.op  = OP_SWITCH;
         c.val = 8'($urandom_range(2, 255));
      end else begin
         c.op = OP_STATUS;
      end
      return c;
   endfunction

   function automatic bit has_effect(dimmer_cmd_type c);
      case (c.op)
         OP_TICK:   return 1'b1;
         OP_SET:    return c.val <= FULL_LEVEL;
         OP_SWITCH: return c.val == SWITCH_OFF || c.val == SWITCH_ON;
         default:   return 1'b0;
      endcase
   endfunction

   initial begin : stimulus
      dimmer_cmd_type c;
      int             useful;
      int             quota;
      int             s;
      logic [7:0]     step_data;
      logic [7:0]     interval_data;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-on settings: step 1, interval 10
      send(OP_TICK, 8'hFF);
      send(OP_STATUS, 8'hAA);
      send(OP_SET, 8'd101);
      send(OP_SET, 8'd255);
      send(OP_SET, 8'd0);            // same as current level, fade ends on next update
      send(OP_TICK, 8'h00);
      send(OP_SWITCH, 8'd2);
      send(OP_SWITCH, 8'd255);
      send(OP_SWITCH, SWITCH_ON);
      send(OP_TICK, 8'h55, 3);
      send(OP_SET, 8'd100);
      send(OP_SET, 8'd5);
      send(OP_SWITCH, SWITCH_OFF);
      send(OP_SWITCH, SWITCH_ON);
      send(OP_TICK, 8'h0F, 12);
      wait_idle();

      // step 127 via masked data, zero interval, writes to unknown indexes
      csr_write(CSR_STEP_SIZE, 8'hFF);
      csr_write(CSR_UPDATE_INTERVAL, 8'h00);
      csr_write(8'd2, 8'h55);
      csr_write(8'hFF, 8'h00);
      send(OP_SET, 8'd100);
      send(OP_TICK, 8'hF0, 2);
      send(OP_SWITCH, SWITCH_OFF);
      send(OP_TICK, 8'h00);
      wait_idle();

      // zero step: level holds until it equals the goal
      csr_write(CSR_STEP_SIZE, 8'h00);
      csr_write(CSR_UPDATE_INTERVAL, 8'd3);
      send(OP_SET, 8'd80);
      send(OP_TICK, 8'h01, 4);
      send(OP_SET, 8'd0);
      send(OP_TICK, 8'h02, 3);
      wait_idle();

      // long interval, then cut below the elapsed count
      csr_write(CSR_STEP_SIZE, 8'd100);
      csr_write(CSR_UPDATE_INTERVAL, 8'd255);
      send(OP_TICK, 8'h80, 8);
      wait_idle();
      csr_write(CSR_UPDATE_INTERVAL, 8'd1);
      send(OP_SET, 8'd100);
      send(OP_TICK, 8'h7F, 2);
      wait_idle();

      useful = 0;
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 7))
            0:       step_data = 8'h00;
            1:       step_data = 8'h01;
            2:       step_data = 8'd100;
            3:       step_data = 8'hFF;
            default: step_data = {1'($urandom_range(0, 1)), 7'($urandom_range(1, 25))};
         endcase
         case ($urandom_range(0, 9))
            0:       interval_data = 8'h00;
            1:       interval_data = 8'h01;
            2:       interval_data = 8'hFF;
            default: interval_data = 8'($urandom_range(1, 8));
         endcase
         csr_write(CSR_STEP_SIZE, step_data);
         csr_write(CSR_UPDATE_INTERVAL, interval_data);
         calm  = ($urandom_range(0, 3) == 0);
         quota = useful + FADE_ITEMS / PHASES;
         while (useful < quota) begin
            if ($urandom_range(0, 9) == 0) begin
               // a command followed by a run of ticks to carry the fade along
               c.op  = $urandom_range(0, 2) ? OP_SET : OP_SWITCH;
               c.val = (c.op == OP_SET) ? 8'($urandom_range(0, 100))
                                        : ($urandom_range(0, 1) ? SWITCH_ON : SWITCH_OFF);
               cmd_q.push_back(c);
               s = $urandom_range(5, 40);
               send(OP_TICK, 8'($urandom_range(0, 255)), s);
               useful += s + 1;
            end else begin
               c = random_cmd();
               cmd_q.push_back(c);
               if (has_effect(c)) useful++;
            end
         end
         wait_idle();
      end
      calm = 1'b0;

      repeat (8) @(posedge clock);
      $display("%0d items sent, %0d results checked across %0d register writes",
               sent_count, checked_count, setting_count);
      $display("steps 0 to 127 and intervals 0 to 255 exercised, %0d mismatches", fail_count);
      if (fail_count == 0 && level_exp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
